### hdl/gbs_pkg.sv
package gbs_pkg;

    // Kept store geometry
    localparam int MAX_KEPT = 64;
    localparam int KEPT_AW  = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CNT_W    = $clog2(MAX_KEPT + 1);

    // Field widths
    localparam int COORD_W = 16;
    localparam int SIZE_W  = 15;
    localparam int EDGE_W  = COORD_W + 1;
    localparam int AREA_W  = 2 * SIZE_W;
    localparam int UNI_W   = AREA_W + 1;
    localparam int THR_W   = 16;
    localparam int PROD_W  = THR_W + UNI_W;
    localparam int FRAC_W  = 15;
    localparam int IDX_W   = 10;

    localparam logic [THR_W-1:0] THR_RESET = 16'd16384;

    // One kept entry: area, h, w, y, x
    localparam int ENTRY_W = AREA_W + 2 * SIZE_W + 2 * COORD_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } t_gbs_state;

    typedef struct packed {
        logic               load;
        logic               issue;
        logic [KEPT_AW-1:0] addr;
        logic               commit;
    } t_gbs_cmd;

    typedef struct packed {
        logic [CNT_W-1:0] kept_cnt;
        logic             pipe_empty;
        logic             out_free;
    } t_gbs_stat;

endpackage

### hdl/gbs_ctrl.sv
module gbs_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  gbs_pkg::t_gbs_stat  i_stat,
    output gbs_pkg::t_gbs_cmd   o_cmd
);

    gbs_pkg::t_gbs_state          r_state, n_state;
    logic [gbs_pkg::CNT_W-1:0]    r_scan_idx, n_scan_idx;
    logic                         more;

    assign more = (r_scan_idx < i_stat.kept_cnt);

    // Hold state and scan pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= gbs_pkg::ST_IDLE;
            r_scan_idx <= '0;
        end else begin
            r_state    <= n_state;
            r_scan_idx <= n_scan_idx;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            gbs_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = gbs_pkg::ST_SCAN;
            end
            gbs_pkg::ST_SCAN: begin
                if (!more) n_state = gbs_pkg::ST_DRAIN;
            end
            gbs_pkg::ST_DRAIN: begin
                if (i_stat.pipe_empty) n_state = gbs_pkg::ST_COMMIT;
            end
            gbs_pkg::ST_COMMIT: begin
                if (i_stat.out_free) n_state = gbs_pkg::ST_IDLE;
            end
            default: n_state = gbs_pkg::ST_IDLE;
        endcase
    end

    // Commands and scan pointer
    always_comb begin
        o_in_ready   = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.issue  = 1'b0;
        o_cmd.commit = 1'b0;
        o_cmd.addr   = r_scan_idx[gbs_pkg::KEPT_AW-1:0];
        n_scan_idx   = r_scan_idx;
        case (r_state)
            gbs_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
                n_scan_idx = '0;
            end
            gbs_pkg::ST_SCAN: begin
                o_cmd.issue = more;
                if (more) n_scan_idx = r_scan_idx + 1'b1;
            end
            gbs_pkg::ST_DRAIN: begin
                o_cmd.issue = 1'b0;
            end
            gbs_pkg::ST_COMMIT: begin
                o_cmd.commit = i_stat.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

### hdl/gbs_dpath.sv
module gbs_dpath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  gbs_pkg::t_gbs_cmd                i_cmd,
    output gbs_pkg::t_gbs_stat               o_stat,
    input  logic                             i_cfg_wr_en,
    input  logic [gbs_pkg::THR_W-1:0]        i_cfg_wr_data,
    input  logic                             i_frame_start,
    input  logic signed [gbs_pkg::COORD_W-1:0] i_box_x,
    input  logic signed [gbs_pkg::COORD_W-1:0] i_box_y,
    input  logic [gbs_pkg::SIZE_W-1:0]       i_box_w,
    input  logic [gbs_pkg::SIZE_W-1:0]       i_box_h,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_keep,
    output logic [gbs_pkg::IDX_W-1:0]        o_box_index,
    output logic                             o_overflow
);

    localparam int CW = gbs_pkg::COORD_W;
    localparam int SW = gbs_pkg::SIZE_W;
    localparam int EW = gbs_pkg::EDGE_W;
    localparam int AW = gbs_pkg::AREA_W;
    localparam int UW = gbs_pkg::UNI_W;
    localparam int PW = gbs_pkg::PROD_W;

    // Threshold, box, counters
    logic [gbs_pkg::THR_W-1:0]   r_thr;
    logic signed [CW-1:0]        r_x, r_y;
    logic [SW-1:0]               r_w, r_h;
    logic [AW-1:0]               r_area;
    logic [gbs_pkg::CNT_W-1:0]   r_kept_cnt;
    logic [gbs_pkg::IDX_W-1:0]   r_fcnt;
    logic                        r_suppress;

    // Kept store
    logic [gbs_pkg::ENTRY_W-1:0] mem [gbs_pkg::MAX_KEPT];
    logic [gbs_pkg::ENTRY_W-1:0] r_rd_data;

    // Pipeline
    logic [5:0]                  r_v;
    logic signed [EW-1:0]        r_l, r_t, r_r, r_b;
    logic [AW-1:0]               r_ka1, r_ka2, r_ka3;
    logic [SW-1:0]               r_dx, r_dy;
    logic [AW-1:0]               r_inter3, r_inter4, r_inter5;
    logic [UW-1:0]               r_uni;
    logic [PW-1:0]               r_prod;

    logic                        store_full;
    logic signed [CW-1:0]        kx, ky;
    logic [SW-1:0]               kw, kh;
    logic signed [EW-1:0]        ax, ay, ar, ab, bx, by, br, bb;
    logic signed [EW-1:0]        dxs, dys;
    logic [PW-1:0]               scaled;

    assign store_full = (r_kept_cnt == gbs_pkg::CNT_W'(gbs_pkg::MAX_KEPT));

    // Config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= gbs_pkg::THR_RESET;
        end else if (i_cfg_wr_en) begin
            r_thr <= i_cfg_wr_data;
        end
    end

    // Capture the box beat; the area is registered from it in the next cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x <= i_box_x;
            r_y <= i_box_y;
            r_w <= i_box_w;
            r_h <= i_box_h;
        end
        r_area <= AW'(r_w) * AW'(r_h);
    end

    // Kept count, box counter and suppress flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kept_cnt <= '0;
            r_fcnt     <= '0;
            r_suppress <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_suppress <= 1'b0;
                if (i_frame_start) begin
                    r_kept_cnt <= '0;
                    r_fcnt     <= '0;
                end
            end else if (r_v[5] && (scaled > r_prod)) begin
                r_suppress <= 1'b1;
            end
            if (i_cmd.commit) begin
                r_fcnt <= r_fcnt + 1'b1;
                if (!r_suppress && !store_full) r_kept_cnt <= r_kept_cnt + 1'b1;
            end
        end
    end

    // Store write on commit, registered read on issue
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && !r_suppress && !store_full) begin
            mem[r_kept_cnt[gbs_pkg::KEPT_AW-1:0]] <= {r_area, r_h, r_w, r_y, r_x};
        end
        if (i_cmd.issue) begin
            r_rd_data <= mem[i_cmd.addr];
        end
    end

    // Unpack entry, form edges
    assign kx = r_rd_data[CW-1:0];
    assign ky = r_rd_data[2*CW-1:CW];
    assign kw = r_rd_data[2*CW+SW-1:2*CW];
    assign kh = r_rd_data[2*CW+2*SW-1:2*CW+SW];
    assign ax = {r_x[CW-1], r_x};
    assign ay = {r_y[CW-1], r_y};
    assign ar = ax + signed'({2'b00, r_w});
    assign ab = ay + signed'({2'b00, r_h});
    assign bx = {kx[CW-1], kx};
    assign by = {ky[CW-1], ky};
    assign br = bx + signed'({2'b00, kw});
    assign bb = by + signed'({2'b00, kh});
    assign dxs = r_r - r_l;
    assign dys = r_b - r_t;
    assign scaled = {2'b00, r_inter5, {gbs_pkg::FRAC_W{1'b0}}};

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[4:0], i_cmd.issue};
        end
    end

    // Overlap pipeline: edges, spans, intersection, union, scaled threshold
    always_ff @(posedge i_clk) begin
        r_l   <= (ax > bx) ? ax : bx;
        r_t   <= (ay > by) ? ay : by;
        r_r   <= (ar < br) ? ar : br;
        r_b   <= (ab < bb) ? ab : bb;
        r_ka1 <= r_rd_data[gbs_pkg::ENTRY_W-1:2*CW+2*SW];

        r_dx  <= (r_r > r_l) ? dxs[SW-1:0] : '0;
        r_dy  <= (r_b > r_t) ? dys[SW-1:0] : '0;
        r_ka2 <= r_ka1;

        r_inter3 <= AW'(r_dx) * AW'(r_dy);
        r_ka3    <= r_ka2;

        r_uni    <= {1'b0, r_area} + {1'b0, r_ka3} - {1'b0, r_inter3};
        r_inter4 <= r_inter3;

        r_prod   <= PW'(r_thr) * PW'(r_uni);
        r_inter5 <= r_inter4;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_keep      <= !r_suppress;
            o_overflow  <= !r_suppress && store_full;
            o_box_index <= r_fcnt;
        end
    end

    assign o_stat.kept_cnt   = r_kept_cnt;
    assign o_stat.pipe_empty = (r_v == '0);
    assign o_stat.out_free   = !o_out_valid || i_out_ready;

endmodule

### hdl/greedy_box_suppression.sv
// Greedy box suppression over score-sorted boxes.
// Input channel (i_in_valid / o_in_ready): one box per beat with its
// left/top edge, width, height and a frame start flag that empties the
// kept store and restarts the box index before this box is handled.
// Output channel (o_out_valid / i_out_ready): one beat per box with the
// keep bit, the box index within the frame and an overflow flag for a
// surviving box that found the 64-entry kept store full.
// The threshold register is written through i_cfg_wr_en / i_cfg_wr_data;
// the user must write it only while no box is in flight, which the block
// itself does not enforce. It resets to 0.5 in Q1.15.
// A box is checked against each of the N kept boxes, one store read per
// cycle, through a six-stage overlap pipeline; the result is registered
// once the pipeline has drained and the output register is free.
// One box is in flight at a time, so a new box is taken only after the
// previous one is committed. The output register lets a new box be
// taken while the previous result waits; a stalled receiver holds the
// result and blocks only the commit of the next one. Synchronous reset
// clears the counters, the output valid and restores the threshold.
module greedy_box_suppression (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [gbs_pkg::THR_W-1:0]           i_cfg_wr_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_frame_start,
    input  logic signed [gbs_pkg::COORD_W-1:0]  i_box_x,
    input  logic signed [gbs_pkg::COORD_W-1:0]  i_box_y,
    input  logic [gbs_pkg::SIZE_W-1:0]          i_box_w,
    input  logic [gbs_pkg::SIZE_W-1:0]          i_box_h,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_keep,
    output logic [gbs_pkg::IDX_W-1:0]           o_box_index,
    output logic                                o_overflow
);

    gbs_pkg::t_gbs_cmd  cmd;
    gbs_pkg::t_gbs_stat stat;

    gbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    gbs_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_frame_start (i_frame_start),
        .i_box_x       (i_box_x),
        .i_box_y       (i_box_y),
        .i_box_w       (i_box_w),
        .i_box_h       (i_box_h),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_keep        (o_keep),
        .o_box_index   (o_box_index),
        .o_overflow    (o_overflow)
    );

endmodule

### hdl/gbs_chk.sv
module gbs_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_ready,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic                       o_keep,
    input logic [gbs_pkg::IDX_W-1:0]  o_box_index,
    input logic                       o_overflow
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_keep)
            && $stable(o_box_index) && $stable(o_overflow))
        else $error("result beat changed while stalled");

    // Overflow only on a surviving box
    a_ovf_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_overflow |-> o_keep)
        else $error("overflow flagged on a suppressed box");

    // One box in flight: ready drops after an accepted beat
    a_one_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second box accepted while one is in flight");

    // A new result marks a finished box, so the input side is open again
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |=> !o_out_valid || o_in_ready)
        else $error("result appeared without a finished box");

endmodule

bind greedy_box_suppression gbs_chk u_gbs_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_keep      (o_keep),
    .o_box_index (o_box_index),
    .o_overflow  (o_overflow)
);

### tb/sv/greedy_box_suppression_tb.sv
module greedy_box_suppression_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // One input box and the verdict the block must return for it
    typedef struct {
        logic                               frame_start;
        logic signed [gbs_pkg::COORD_W-1:0] x;
        logic signed [gbs_pkg::COORD_W-1:0] y;
        logic [gbs_pkg::SIZE_W-1:0]         w;
        logic [gbs_pkg::SIZE_W-1:0]         h;
    } t_box;

    typedef struct {
        logic                      keep;
        logic [gbs_pkg::IDX_W-1:0] index;
        logic                      overflow;
    } t_verdict;

    // Spot around which a group of overlapping boxes is scattered
    typedef struct {
        int cx;
        int cy;
        int sw;
        int sh;
    } t_cluster;

    typedef enum logic [1:0] {
        RDY_OPEN,
        RDY_COIN,
        RDY_SPARSE,
        RDY_PERIODIC
    } t_ready_mode;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_cfg_wr_en = 1'b0;
    logic [gbs_pkg::THR_W-1:0]          i_cfg_wr_data = '0;
    logic                               i_in_valid = 1'b0;
    logic                               o_in_ready;
    logic                               i_frame_start = 1'b0;
    logic signed [gbs_pkg::COORD_W-1:0] i_box_x = '0;
    logic signed [gbs_pkg::COORD_W-1:0] i_box_y = '0;
    logic [gbs_pkg::SIZE_W-1:0]         i_box_w = '0;
    logic [gbs_pkg::SIZE_W-1:0]         i_box_h = '0;
    logic                               o_out_valid;
    logic                               i_out_ready = 1'b0;
    logic                               o_keep;
    logic [gbs_pkg::IDX_W-1:0]          o_box_index;
    logic                               o_overflow;

    // Shadow of the kept store, counters and threshold
    t_box                       kept_box [gbs_pkg::MAX_KEPT];
    logic [gbs_pkg::AREA_W-1:0] kept_area [gbs_pkg::MAX_KEPT];
    int unsigned                kept_total = 0;
    logic [gbs_pkg::IDX_W-1:0]  frame_index = '0;
    logic [gbs_pkg::THR_W-1:0]  threshold = gbs_pkg::THR_RESET;

    t_verdict pending_verdicts [$];

    int burst_left = 0;
    int mismatches = 0;
    int boxes_sent = 0;
    int frames_sent = 0;
    int threshold_writes = 0;
    int results_seen = 0;
    int results_kept = 0;
    int results_overflow = 0;

    t_ready_mode ready_mode = RDY_OPEN;
    int          ready_span = 0;

    greedy_box_suppression DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_frame_start (i_frame_start),
        .i_box_x       (i_box_x),
        .i_box_y       (i_box_y),
        .i_box_w       (i_box_w),
        .i_box_h       (i_box_h),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_keep        (o_keep),
        .o_box_index   (o_box_index),
        .o_overflow    (o_overflow)
    );

    // 8 ns clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic t_box mk_box(input logic fs, input int x, input int y,
                                    input int w, input int h);
        t_box bx;
        bx.frame_start = fs;
        bx.x = x[gbs_pkg::COORD_W-1:0];
        bx.y = y[gbs_pkg::COORD_W-1:0];
        bx.w = w[gbs_pkg::SIZE_W-1:0];
        bx.h = h[gbs_pkg::SIZE_W-1:0];
        return bx;
    endfunction

    function automatic int clamp(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Intersection area; boxes that only touch give zero
    function automatic longint unsigned overlap_area(input t_box a, input t_box b);
        int lft, top, rgt, bot;
        lft = (int'(a.x) > int'(b.x)) ? int'(a.x) : int'(b.x);
        top = (int'(a.y) > int'(b.y)) ? int'(a.y) : int'(b.y);
        rgt = (int'(a.x) + int'(a.w) < int'(b.x) + int'(b.w)) ?
              int'(a.x) + int'(a.w) : int'(b.x) + int'(b.w);
        bot = (int'(a.y) + int'(a.h) < int'(b.y) + int'(b.h)) ?
              int'(a.y) + int'(a.h) : int'(b.y) + int'(b.h);
        if (rgt <= lft || bot <= top) begin
            return 0;
        end
        return longint'(rgt - lft) * longint'(bot - top);
    endfunction

    // Greedy suppression of one box against the kept store; updates the shadow state
    function automatic t_verdict judge_box(input t_box bx);
        t_verdict        v;
        longint unsigned area, inter, uni;
        if (bx.frame_start) begin
            kept_total = 0;
            frame_index = '0;
        end
        area = 64'(bx.w) * 64'(bx.h);
        v.keep = 1'b1;
        v.overflow = 1'b0;
        for (int i = 0; i < kept_total; i++) begin
            inter = overlap_area(bx, kept_box[i]);
            uni = area + 64'(kept_area[i]) - inter;
            if ((inter << gbs_pkg::FRAC_W) > 64'(threshold) * uni) begin
                v.keep = 1'b0;
            end
        end
        if (v.keep) begin
            if (kept_total < gbs_pkg::MAX_KEPT) begin
                kept_box[kept_total] = bx;
                kept_area[kept_total] = area[gbs_pkg::AREA_W-1:0];
                kept_total++;
            end else begin
                v.overflow = 1'b1;
            end
        end
        v.index = frame_index;
        frame_index = frame_index + 1'b1;
        return v;
    endfunction

    // Send one box, idling between bursts, and record its verdict once accepted
    task automatic send_box(input t_box bx);
        int       gap;
        t_verdict verdict;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 120)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        i_in_valid    <= 1'b1;
        i_frame_start <= bx.frame_start;
        i_box_x       <= bx.x;
        i_box_y       <= bx.y;
        i_box_w       <= bx.w;
        i_box_h       <= bx.h;
        do @(posedge i_clk); while (!o_in_ready);
        verdict = judge_box(bx);
        pending_verdicts.insert(pending_verdicts.size(), verdict);
        boxes_sent++;
        if (bx.frame_start) begin
            frames_sent++;
        end
    endtask

    // Drain the block, then write the threshold
    task automatic write_threshold(input logic [gbs_pkg::THR_W-1:0] value);
        i_in_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        threshold = value;
        threshold_writes++;
    endtask

    function automatic t_cluster pick_cluster();
        t_cluster c;
        c.sw = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 32767) : $urandom_range(8, 2048);
        c.sh = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 32767) : $urandom_range(8, 2048);
        c.cx = int'($urandom_range(0, 65535)) - 32768;
        c.cy = int'($urandom_range(0, 65535)) - 32768;
        return c;
    endfunction

    function automatic t_box jitter_box(input t_cluster c);
        int dx, dy, dw, dh;
        dx = int'($urandom_range(0, c.sw / 2)) - c.sw / 4;
        dy = int'($urandom_range(0, c.sh / 2)) - c.sh / 4;
        dw = int'($urandom_range(0, c.sw / 4)) - c.sw / 8;
        dh = int'($urandom_range(0, c.sh / 4)) - c.sh / 8;
        return mk_box(1'b0, clamp(c.cx + dx, -32768, 32767), clamp(c.cy + dy, -32768, 32767),
                      clamp(c.sw + dw, 0, 32767), clamp(c.sh + dh, 0, 32767));
    endfunction

    // One frame: mostly boxes scattered around a few spots, some repeats and noise
    task automatic run_frame(input int length, input int groups);
        t_cluster spot [$];
        t_box     bx, prev;
        int       pick;
        repeat (groups) spot.insert(spot.size(), pick_cluster());
        for (int n = 0; n < length; n++) begin
            pick = $urandom_range(0, 19);
            if (n > 0 && pick < 2) begin
                bx = prev;
            end else if (pick < 4) begin
                bx = mk_box(1'b0, int'($urandom_range(0, 65535)) - 32768,
                            int'($urandom_range(0, 65535)) - 32768,
                            $urandom_range(0, 32767), $urandom_range(0, 32767));
            end else begin
                bx = jitter_box(spot[$urandom_range(0, groups - 1)]);
            end
            // Now and then a frame carries on without a start flag
            bx.frame_start = (n == 0) ? ($urandom_range(0, 9) != 0) : 1'b0;
            send_box(bx);
            prev = bx;
        end
    endtask

    task automatic test_reset_threshold();
        send_box(mk_box(1'b1, -32768, -32768, 32767, 32767));
        send_box(mk_box(1'b0, -32768, -32768, 32767, 32767));
        // Far corner: right and bottom edges need the 17th bit
        send_box(mk_box(1'b0, 32767, 32767, 32767, 32767));
        send_box(mk_box(1'b0, 32767, 32767, 32767, 32767));
        // Touch the first box on its right and bottom edges
        send_box(mk_box(1'b0, -1, -32768, 100, 100));
        send_box(mk_box(1'b0, -32768, -1, 100, 100));
        // IoU of exactly one half is not above the threshold
        send_box(mk_box(1'b1, 0, 0, 300, 100));
        send_box(mk_box(1'b0, 100, 0, 300, 100));
        send_box(mk_box(1'b0, 0, 0, 300, 100));
        send_box(mk_box(1'b0, 1, 0, 300, 100));
    endtask

    task automatic test_zero_union();
        send_box(mk_box(1'b1, 50, 50, 0, 0));
        send_box(mk_box(1'b0, 50, 50, 0, 0));
        send_box(mk_box(1'b0, 50, 40, 0, 20));
        send_box(mk_box(1'b0, 40, 50, 20, 0));
    endtask

    task automatic test_threshold_extremes();
        // Zero threshold: any overlap suppresses, touching does not
        write_threshold('0);
        send_box(mk_box(1'b1, 0, 0, 160, 160));
        send_box(mk_box(1'b0, 159, 159, 160, 160));
        send_box(mk_box(1'b0, 160, 0, 160, 160));
        // Threshold of one and above: identical boxes survive
        write_threshold(16'd32768);
        send_box(mk_box(1'b1, -4000, 300, 320, 48));
        send_box(mk_box(1'b0, -4000, 300, 320, 48));
        write_threshold('1);
        send_box(mk_box(1'b1, 77, -77, 5, 9000));
        send_box(mk_box(1'b0, 77, -77, 5, 9000));
    endtask

    task automatic test_store_full();
        write_threshold(16'd20000);
        send_box(mk_box(1'b1, 0, 0, 100, 100));
        // Fill the rest of the store with zero-area boxes, which always survive
        for (int n = 0; n < gbs_pkg::MAX_KEPT - 1; n++) begin
            send_box(mk_box(1'b0, n * 16, -500, 0, $urandom_range(0, 32767)));
        end
        send_box(mk_box(1'b0, 0, 0, 100, 100));
        // Survivor with a full store, then a copy that must not see it
        send_box(mk_box(1'b0, 5000, 5000, 10, 10));
        send_box(mk_box(1'b0, 5000, 5000, 10, 10));
    endtask

    task automatic test_random_frames();
        logic [gbs_pkg::THR_W-1:0] thr;
        int                        phase_boxes, len;
        for (int p = 0; p < 7; p++) begin
            case (p)
                0:       thr = 16'd32768;
                1:       thr = '0;
                2:       thr = '1;
                3:       thr = gbs_pkg::THR_RESET;
                4:       thr = gbs_pkg::THR_W'($urandom_range(1, 8000));
                default: thr = gbs_pkg::THR_W'($urandom_range(8000, 40000));
            endcase
            write_threshold(thr);
            phase_boxes = 0;
            while (phase_boxes < 95) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 100)
                                                  : $urandom_range(1, 40);
                run_frame(len, $urandom_range(1, len / 4 + 1));
                phase_boxes += len;
            end
        end
    endtask

    // One long frame: the store overflows and the box index wraps
    task automatic test_long_frame();
        write_threshold(gbs_pkg::THR_W'($urandom_range(12000, 24000)));
        run_frame(1100, 90);
    endtask

    // Receiver stalls, switching among open, coin-flip, sparse and periodic patterns
    always @(posedge i_clk) begin
        if (ready_span == 0) begin
            ready_mode = t_ready_mode'($urandom_range(0, 3));
            ready_span = $urandom_range(16, 300);
        end
        ready_span--;
        case (ready_mode)
            RDY_OPEN:   i_out_ready <= 1'b1;
            RDY_COIN:   i_out_ready <= 1'($urandom_range(0, 1));
            RDY_SPARSE: i_out_ready <= ($urandom_range(0, 7) == 0);
            default:    i_out_ready <= ((ready_span % 32) >= 20);
        endcase
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10) begin
            $display("ERROR at %0t ns: %s", $time, what);
        end
    endtask

    // Compare each result beat with the oldest expected verdict
    always @(posedge i_clk) begin : check_result
        t_verdict want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch($sformatf("unexpected result keep=%0b index=%0d overflow=%0b",
                                          o_keep, o_box_index, o_overflow));
            end else begin
                want = pending_verdicts.pop_front();
                if (o_keep !== want.keep) begin
                    report_mismatch($sformatf("result %0d keep: expected %0b, got %0b",
                                              results_seen, want.keep, o_keep));
                end
                if (o_box_index !== want.index) begin
                    report_mismatch($sformatf("result %0d box_index: expected %0d, got %0d",
                                              results_seen, want.index, o_box_index));
                end
                if (o_overflow !== want.overflow) begin
                    report_mismatch($sformatf("result %0d overflow: expected %0b, got %0b",
                                              results_seen, want.overflow, o_overflow));
                end
                results_kept += int'(want.keep);
                results_overflow += int'(want.overflow);
            end
            results_seen++;
        end
    end

    // Give up on a hung run
    initial begin
        #12ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_threshold();
        test_zero_union();
        test_threshold_extremes();
        test_store_full();
        test_random_frames();
        test_long_frame();

        // Drain the last results and watch for stray beats
        i_in_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("Sent %0d boxes in %0d frames under %0d threshold settings;",
                 boxes_sent, frames_sent, threshold_writes + 1);
        $display("checked %0d results: %0d kept, %0d suppressed, %0d store overflows.",
                 results_seen, results_kept, results_seen - results_kept, results_overflow);
        if (mismatches == 0 && pending_verdicts.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
